@@ rtl/mtv_stream_deframer_unit_defines.svh @@
// assertion macros for the deframer
`ifndef MTV_STREAM_DEFRAMER_UNIT_DEFINES_SVH
`define MTV_STREAM_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked at every clock edge outside reset
`define MTVD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MTVD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MTVD_ASSERT_IMP(lbl, ante, cons, msg)
`define MTVD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/mtvd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mtvd_pkg;

    // header layout
    localparam logic [9:0] HDR_LAST     = 10'd511;
    localparam logic [9:0] OFS_BR_LO    = 10'd46;
    localparam logic [9:0] OFS_BR_HI    = 10'd47;
    localparam logic [9:0] OFS_W_LO     = 10'd52;
    localparam logic [9:0] OFS_W_HI     = 10'd53;
    localparam logic [9:0] OFS_H_LO     = 10'd54;
    localparam logic [9:0] OFS_H_HI     = 10'd55;
    localparam logic [9:0] OFS_SEG_LO   = 10'd56;
    localparam logic [9:0] OFS_SEG_HI   = 10'd57;
    localparam logic [9:0] OFS_SUB_LO   = 10'd62;
    localparam logic [9:0] OFS_SUB_HI   = 10'd63;

    // audio subchunk layout: padding then payload
    localparam logic [15:0] PAD_BYTES     = 16'd12;
    localparam logic [15:0] SUBCHUNK_LAST = 16'd511;

    // byte tags
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_PAD     = 3'd1;
    localparam logic [2:0] KIND_AUDIO   = 3'd2;
    localparam logic [2:0] KIND_VIDEO   = 3'd3;
    localparam logic [2:0] KIND_DISCARD = 3'd4;

    // sticky error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_DIM      = 2'd1;
    localparam logic [1:0] ERR_NO_AUDIO = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_AUDIO  = 2'd1,
        PH_VIDEO  = 2'd2,
        PH_ERROR  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  byte_kind;
        logic        packet_last;
        logic        header_done;
        logic [1:0]  error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [13:0] frame_rate;
        logic [15:0] audio_bitrate;
    } out_beat_t;

endpackage

`default_nettype wire

@@ rtl/mtvd_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// byte stream into the deframer
interface mtvd_in_if import mtvd_pkg::*; ();
    logic     valid;
    logic     ready;
    in_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/mtvd_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// tagged byte stream out of the deframer
interface mtvd_out_if import mtvd_pkg::*; ();
    logic      valid;
    logic      ready;
    out_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/mtv_stream_deframer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial deframer for the MTV container. Every byte on feed gives one tagged
// beat on tag, passed through with its kind, packet end mark, sticky error and the
// header values as they stand after that byte. Ordinary bytes pass through a single
// output register, and a new byte is taken whenever that register is empty or being
// read by tag. The last header byte (byte 511) takes longer: a shared 16-bit
// restoring divider, one quotient bit per cycle, derives a missing width or height
// and then the frame rate. At most two divisions of 16 steps run, and each of the
// four jobs (width, height, frame rate, show) is taken up in turn. Its beat is shown
// once the output slot is free, and the next byte is taken back in idle.
// start_of_file on a byte restarts header parsing at that byte.

`include "mtv_stream_deframer_unit_defines.svh"

module mtv_stream_deframer_unit import mtvd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    mtvd_in_if.sink     feed,
    mtvd_out_if.source  tag
);

    localparam int DIV_STEPS = 16;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PICK = 3'b010,
        S_DIV  = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        JOB_W,
        JOB_H,
        JOB_F,
        JOB_END
    } job_t;

    state_t      state_reg, state_next;
    job_t        job_reg, job_next;
    logic [9:0]  header_pos_reg, header_pos_next;
    logic [15:0] bitrate_reg, bitrate_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] vseg_reg, vseg_next;
    logic [15:0] subseg_count_reg, subseg_count_next;
    logic [15:0] subseg_index_reg, subseg_index_next;
    logic [15:0] chunk_offset_reg, chunk_offset_next;
    phase_t      phase_reg, phase_next;
    logic [1:0]  error_reg, error_next;
    logic [13:0] fps_reg, fps_next;
    logic [7:0]  fin_byte_reg, fin_byte_next;
    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_beat_reg, out_beat_next;

    // divider registers
    logic [15:0]      dvd_reg, dvd_next;
    logic [15:0]      dsr_reg, dsr_next;
    logic [15:0]      rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic        in_fire;
    logic        slot_free;
    logic        sof;
    logic [7:0]  b;
    logic [9:0]  e_pos;
    logic [15:0] e_bitrate, e_width, e_height, e_vseg, e_count, e_index, e_offset;
    phase_t      e_phase;
    logic [1:0]  e_error;
    logic [13:0] e_fps;
    logic [2:0]  b_kind;
    logic        b_last;
    logic [15:0] index_inc;
    logic [16:0] offset_inc;
    logic [16:0] div_trial;
    logic        div_ge;
    logic [15:0] div_rem;
    logic [15:0] div_q;

    // handshake
    assign slot_free = !out_valid_reg || tag.ready;
    assign feed.ready = (state_reg == S_IDLE) && slot_free;
    assign in_fire = feed.valid && feed.ready;
    assign tag.valid = out_valid_reg;
    assign tag.payload = out_beat_reg;

    // state as seen by this byte, after an optional restart
    assign sof       = feed.payload.start_of_file;
    assign b         = feed.payload.data_byte;
    assign e_pos     = sof ? 10'd0 : header_pos_reg;
    assign e_bitrate = sof ? 16'd0 : bitrate_reg;
    assign e_width   = sof ? 16'd0 : width_reg;
    assign e_height  = sof ? 16'd0 : height_reg;
    assign e_vseg    = sof ? 16'd0 : vseg_reg;
    assign e_count   = sof ? 16'd0 : subseg_count_reg;
    assign e_index   = sof ? 16'd0 : subseg_index_reg;
    assign e_offset  = sof ? 16'd0 : chunk_offset_reg;
    assign e_phase   = sof ? PH_HEADER : phase_reg;
    assign e_error   = sof ? ERR_NONE : error_reg;
    assign e_fps     = sof ? 14'd0 : fps_reg;

    assign index_inc  = e_index + 16'd1;
    assign offset_inc = {1'b0, e_offset} + 17'd1;

    // one restoring divide step
    assign div_trial = {rem_reg, dvd_reg[15]};
    assign div_ge    = div_trial >= {1'b0, dsr_reg};
    assign div_rem   = div_ge ? 16'(div_trial - {1'b0, dsr_reg}) : div_trial[15:0];
    assign div_q     = {dvd_reg[14:0], div_ge};

    // byte parsing and header finish sequencer
    always_comb
    begin
        state_next        = state_reg;
        job_next          = job_reg;
        header_pos_next   = header_pos_reg;
        bitrate_next      = bitrate_reg;
        width_next        = width_reg;
        height_next       = height_reg;
        vseg_next         = vseg_reg;
        subseg_count_next = subseg_count_reg;
        subseg_index_next = subseg_index_reg;
        chunk_offset_next = chunk_offset_reg;
        phase_next        = phase_reg;
        error_next        = error_reg;
        fps_next          = fps_reg;
        fin_byte_next     = fin_byte_reg;
        out_beat_next     = out_beat_reg;
        out_valid_next    = out_valid_reg && !tag.ready;
        dvd_next          = dvd_reg;
        dsr_next          = dsr_reg;
        rem_next          = rem_reg;
        cnt_next          = cnt_reg;
        b_kind            = KIND_HEADER;
        b_last            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    header_pos_next   = e_pos;
                    bitrate_next      = e_bitrate;
                    width_next        = e_width;
                    height_next       = e_height;
                    vseg_next         = e_vseg;
                    subseg_count_next = e_count;
                    subseg_index_next = e_index;
                    chunk_offset_next = e_offset;
                    phase_next        = e_phase;
                    error_next        = e_error;
                    fps_next          = e_fps;

                    unique case (e_phase)
                        PH_HEADER:
                        begin
                            b_kind = KIND_HEADER;
                            // little-endian field capture
                            unique case (e_pos)
                                OFS_BR_LO:  bitrate_next = {e_bitrate[15:8], b};
                                OFS_BR_HI:  bitrate_next = {b, e_bitrate[7:0]};
                                OFS_W_LO:   width_next = {e_width[15:8], b};
                                OFS_W_HI:   width_next = {b, e_width[7:0]};
                                OFS_H_LO:   height_next = {e_height[15:8], b};
                                OFS_H_HI:   height_next = {b, e_height[7:0]};
                                OFS_SEG_LO: vseg_next = {e_vseg[15:8], b};
                                OFS_SEG_HI: vseg_next = {b, e_vseg[7:0]};
                                OFS_SUB_LO: subseg_count_next = {e_count[15:8], b};
                                OFS_SUB_HI: subseg_count_next = {b, e_count[7:0]};
                                default:    ;
                            endcase
                            if (e_pos >= HDR_LAST)
                            begin
                                header_pos_next = 10'd0;
                                fin_byte_next   = b;
                                job_next        = JOB_W;
                                state_next      = S_PICK;
                            end
                            else
                            begin
                                header_pos_next = e_pos + 10'd1;
                            end
                        end
                        PH_AUDIO:
                        begin
                            b_kind = (e_offset < PAD_BYTES) ? KIND_PAD : KIND_AUDIO;
                            if (e_offset >= SUBCHUNK_LAST)
                            begin
                                b_last            = 1'b1;
                                chunk_offset_next = 16'd0;
                                subseg_index_next = index_inc;
                                if (index_inc >= e_count)
                                begin
                                    subseg_index_next = 16'd0;
                                    phase_next        = PH_VIDEO;
                                end
                            end
                            else
                            begin
                                chunk_offset_next = offset_inc[15:0];
                            end
                        end
                        PH_VIDEO:
                        begin
                            b_kind = KIND_VIDEO;
                            if (offset_inc >= {1'b0, e_vseg})
                            begin
                                b_last            = 1'b1;
                                chunk_offset_next = 16'd0;
                                subseg_index_next = 16'd0;
                                phase_next        = PH_AUDIO;
                            end
                            else
                            begin
                                chunk_offset_next = offset_inc[15:0];
                            end
                        end
                        PH_ERROR:
                        begin
                            b_kind = KIND_DISCARD;
                        end
                    endcase

                    // every byte but the last header byte goes straight to the output register
                    if (state_next == S_IDLE)
                    begin
                        out_valid_next = 1'b1;
                        out_beat_next  = '{byte_out: b, byte_kind: b_kind,
                                           packet_last: b_last, header_done: 1'b0,
                                           error_code: error_next,
                                           image_width: width_next,
                                           image_height: height_next,
                                           frame_rate: fps_next,
                                           audio_bitrate: bitrate_next};
                    end
                end
            end
            S_PICK:
            begin
                unique case (job_reg)
                    JOB_W:
                    begin
                        if (width_reg == 16'd0 && height_reg != 16'd0)
                        begin
                            dvd_next   = {1'b0, vseg_reg[15:1]};
                            dsr_next   = height_reg;
                            rem_next   = 16'd0;
                            cnt_next   = CNT_W'(DIV_STEPS - 1);
                            state_next = S_DIV;
                        end
                        else
                        begin
                            job_next = JOB_H;
                        end
                    end
                    JOB_H:
                    begin
                        if (height_reg == 16'd0 && width_reg != 16'd0)
                        begin
                            dvd_next   = {1'b0, vseg_reg[15:1]};
                            dsr_next   = width_reg;
                            rem_next   = 16'd0;
                            cnt_next   = CNT_W'(DIV_STEPS - 1);
                            state_next = S_DIV;
                        end
                        else
                        begin
                            job_next = JOB_F;
                        end
                    end
                    JOB_F:
                    begin
                        if (width_reg == 16'd0 || height_reg == 16'd0 || vseg_reg == 16'd0)
                        begin
                            error_next = ERR_DIM;
                            phase_next = PH_ERROR;
                            job_next   = JOB_END;
                        end
                        else if (subseg_count_reg == 16'd0)
                        begin
                            error_next = ERR_NO_AUDIO;
                            phase_next = PH_ERROR;
                            job_next   = JOB_END;
                        end
                        else
                        begin
                            dvd_next   = {2'b00, bitrate_reg[15:2]};
                            dsr_next   = subseg_count_reg;
                            rem_next   = 16'd0;
                            cnt_next   = CNT_W'(DIV_STEPS - 1);
                            state_next = S_DIV;
                        end
                    end
                    JOB_END:
                    begin
                        // show the last header beat once the output slot is free
                        if (slot_free)
                        begin
                            out_valid_next = 1'b1;
                            out_beat_next  = '{byte_out: fin_byte_reg,
                                               byte_kind: KIND_HEADER,
                                               packet_last: 1'b0, header_done: 1'b1,
                                               error_code: error_reg,
                                               image_width: width_reg,
                                               image_height: height_reg,
                                               frame_rate: fps_reg,
                                               audio_bitrate: bitrate_reg};
                            state_next     = S_IDLE;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                dvd_next = div_q;
                rem_next = div_rem;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_PICK;
                    unique case (job_reg)
                        JOB_W:
                        begin
                            width_next = div_q;
                            job_next   = JOB_H;
                        end
                        JOB_H:
                        begin
                            height_next = div_q;
                            job_next    = JOB_F;
                        end
                        JOB_F:
                        begin
                            fps_next          = div_q[13:0];
                            phase_next        = PH_AUDIO;
                            subseg_index_next = 16'd0;
                            chunk_offset_next = 16'd0;
                            job_next          = JOB_END;
                        end
                        JOB_END:
                        begin
                            job_next = JOB_END;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and header state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            job_reg          <= JOB_W;
            header_pos_reg   <= 10'd0;
            bitrate_reg      <= 16'd0;
            width_reg        <= 16'd0;
            height_reg       <= 16'd0;
            vseg_reg         <= 16'd0;
            subseg_count_reg <= 16'd0;
            subseg_index_reg <= 16'd0;
            chunk_offset_reg <= 16'd0;
            phase_reg        <= PH_HEADER;
            error_reg        <= ERR_NONE;
            fps_reg          <= 14'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            job_reg          <= job_next;
            header_pos_reg   <= header_pos_next;
            bitrate_reg      <= bitrate_next;
            width_reg        <= width_next;
            height_reg       <= height_next;
            vseg_reg         <= vseg_next;
            subseg_count_reg <= subseg_count_next;
            subseg_index_reg <= subseg_index_next;
            chunk_offset_reg <= chunk_offset_next;
            phase_reg        <= phase_next;
            error_reg        <= error_next;
            fps_reg          <= fps_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload and divider datapath
    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
        fin_byte_reg <= fin_byte_next;
        dvd_reg      <= dvd_next;
        dsr_reg      <= dsr_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
    end

    // checks
    `MTVD_ASSERT_IMP(a_stream_no_error, phase_reg == PH_AUDIO || phase_reg == PH_VIDEO, error_reg == ERR_NONE, "payload phase with an error set")
    `MTVD_ASSERT_IMP(a_done_is_header, out_valid_reg && out_beat_reg.header_done, out_beat_reg.byte_kind == KIND_HEADER && !out_beat_reg.packet_last, "header_done beat not tagged header")
    `MTVD_ASSERT_IMP(a_discard_has_error, out_valid_reg && out_beat_reg.byte_kind == KIND_DISCARD, out_beat_reg.error_code != ERR_NONE, "discarded beat without error")
    `MTVD_ASSERT_NXT(a_div_nonzero, state_reg == S_PICK && state_next == S_DIV, dsr_reg != 16'd0, "divider started with zero divisor")

endmodule

`default_nettype wire
